// ----- rtl/mck_pkg.sv -----
// Morse character keyer: shared types, constants, code table and helpers.
// No dependencies; every other file imports this package.
package mck_pkg;

   localparam int CHAR_W     = 8;
   localparam int TICKS_W    = 16;
   localparam int DUR_W      = 18;
   localparam int BIT_W      = 3;
   localparam int NUM_LETTERS = 26;
   localparam int NUM_CODES   = 36;
   localparam int IDX_W       = $clog2(NUM_CODES);

   localparam logic [TICKS_W-1:0] ELEMENT_TICKS_RESET = 16'd100;

   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
   localparam logic [CHAR_W-1:0] DIGIT_0    = 8'h30;
   localparam logic [CHAR_W-1:0] DIGIT_9    = 8'h39;
   localparam logic [CHAR_W-1:0] UPPER_A    = 8'h41;
   localparam logic [CHAR_W-1:0] UPPER_Z    = 8'h5A;
   localparam logic [CHAR_W-1:0] LOWER_A    = 8'h61;
   localparam logic [CHAR_W-1:0] LOWER_Z    = 8'h7A;

   localparam logic [BIT_W-1:0] LAST_BIT = 3'd7;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CODE_TABLE [NUM_CODES] = '{
      8'hA0, 8'h18, 8'h58, 8'h30, 8'h40, 8'h48, 8'h70, 8'h08, 8'h20, 8'hE8,
      8'hB0, 8'h28, 8'hE0, 8'h60, 8'hF0, 8'h68, 8'hB8, 8'h50, 8'h10, 8'hC0,
      8'h90, 8'h88, 8'hD0, 8'h98, 8'hD8, 8'h38,
      8'hFC, 8'hF4, 8'hE4, 8'hC4, 8'h84, 8'h04, 8'h0C, 8'h1C, 8'h3C, 8'h7C
   };

   typedef enum logic [1:0] {
      KIND_GAP,
      KIND_BARE,
      KIND_CODE
   } kind_type;

   typedef enum logic [1:0] {
      UNITS_DOT,
      UNITS_DASH,
      UNITS_GAP
   } units_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ON,
      BK_OFF
   } back_state_type;

   typedef struct packed {
      kind_type          kind;
      logic [CHAR_W-1:0] code;
      logic [BIT_W-1:0]  first_bit;
      logic              eom;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [CHAR_W-1:0] char_code(input logic [CHAR_W-1:0] ch);
      logic [IDX_W-1:0] idx;
      idx = '0;
      if (ch >= DIGIT_0 && ch <= DIGIT_9) begin
         idx = IDX_W'(ch - DIGIT_0) + IDX_W'(NUM_LETTERS);
      end else if (ch >= UPPER_A && ch <= UPPER_Z) begin
         idx = IDX_W'(ch - UPPER_A);
      end else if (ch >= LOWER_A && ch <= LOWER_Z) begin
         idx = IDX_W'(ch - LOWER_A);
      end
      return CODE_TABLE[idx];
   endfunction

   function automatic logic [DUR_W-1:0] seg_ticks(input units_type units,
                                                  input logic [TICKS_W-1:0] ticks);
      logic [DUR_W-1:0] t;
      logic [DUR_W-1:0] r;
      t = DUR_W'(ticks);
      case (units)
         UNITS_DOT:  r = t;
         UNITS_DASH: r = (t << 1) + t;
         UNITS_GAP:  r = t << 2;
         default:    r = t;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/mck_ifs.sv -----
// Morse character keyer: request, response and register-write channel interfaces.
// Depends on mck_pkg for field widths.
interface mck_req_if import mck_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              end_of_message;

   modport source (output valid, character, end_of_message, input ready);
   modport sink   (input valid, character, end_of_message, output ready);
endinterface

interface mck_rsp_if import mck_pkg::*;;
   logic             valid;
   logic             ready;
   logic             key_on;
   logic [DUR_W-1:0] duration_ticks;
   logic             last_of_run;
   logic             message_done;

   modport source (output valid, key_on, duration_ticks, last_of_run, message_done,
                   input ready);
   modport sink   (input valid, key_on, duration_ticks, last_of_run, message_done,
                   output ready);
endinterface

interface mck_csr_if import mck_pkg::*;;
   logic               valid;
   logic               ready;
   logic [TICKS_W-1:0] element_ticks;

   modport source (output valid, element_ticks, input ready);
   modport sink   (input valid, element_ticks, output ready);
endinterface

// ----- rtl/mck_front.sv -----
// Morse character keyer front end: accepts characters, looks up the code
// and classifies the word for the back end. Depends on mck_pkg, mck_ifs.
module mck_front import mck_pkg::*; (
   mck_req_if.sink  req,
   input  qstat_type qstat,
   output logic      push,
   output item_type  item
);

   logic [CHAR_W-1:0] code;
   logic [BIT_W-1:0]  pos;
   logic              found;

   assign req.ready = !qstat.full;
   assign push      = req.valid && !qstat.full;

   // lowest set bit among bits 1..7 is the start marker
   always_comb begin
      code  = char_code(req.character);
      pos   = LAST_BIT;
      found = 1'b0;
      for (int b = CHAR_W - 1; b >= 1; b--) begin
         if (code[b]) begin
            pos   = BIT_W'(b);
            found = 1'b1;
         end
      end
   end

   always_comb begin
      item.code      = code;
      item.eom       = req.end_of_message;
      item.first_bit = BIT_W'(pos + 3'd1);
      if (req.character == SPACE_CHAR) begin
         item.kind = KIND_GAP;
      end else if (!found || pos == LAST_BIT) begin
         item.kind = KIND_BARE;
      end else begin
         item.kind = KIND_CODE;
      end
   end

endmodule

// ----- rtl/mck_queue.sv -----
// Morse character keyer: short FIFO between front end and back end.
// Depends on mck_pkg.
module mck_queue import mck_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   input  logic      pop,
   output item_type  head,
   output qstat_type qstat
);

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head        = mem_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/mck_back.sv -----
// Morse character keyer back end: walks the code bits of one character and emits one keying
// segment per cycle into the output register while it is free. Depends on mck_pkg, mck_ifs.
module mck_back import mck_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [TICKS_W-1:0] element_ticks,
   input  item_type           head,
   input  qstat_type          qstat,
   output logic               pop,
   mck_rsp_if.source          rsp
);

   back_state_type     state_ff, state_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [CHAR_W-1:0]  code_ff, code_in;
   logic               eom_ff, eom_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               key_ff, key_in;
   logic [DUR_W-1:0]   dur_ff, dur_in;
   logic               last_ff, last_in;
   logic               done_ff, done_in;

   logic               out_free;
   logic               emit;
   logic               seg_key;
   units_type          seg_units;
   logic               seg_last;
   logic               seg_done;

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!qstat.empty && out_free && head.kind == KIND_CODE) begin
               state_in = BK_OFF;
            end
         end
         BK_ON: begin
            if (out_free) begin
               state_in = BK_OFF;
            end
         end
         BK_OFF: begin
            if (out_free) begin
               state_in = (bit_ff == LAST_BIT) ? BK_IDLE : BK_ON;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      emit      = 1'b0;
      seg_key   = 1'b0;
      seg_units = UNITS_DOT;
      seg_last  = 1'b0;
      seg_done  = 1'b0;
      bit_in    = bit_ff;
      code_in   = code_ff;
      eom_in    = eom_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!qstat.empty && out_free) begin
               pop     = 1'b1;
               emit    = 1'b1;
               code_in = head.code;
               eom_in  = head.eom;
               bit_in  = head.first_bit;
               case (head.kind)
                  KIND_GAP: begin
                     seg_units = UNITS_GAP;
                     seg_last  = 1'b1;
                     seg_done  = head.eom;
                  end
                  KIND_BARE: begin
                     seg_units = head.eom ? UNITS_DOT : UNITS_GAP;
                     seg_last  = 1'b1;
                     seg_done  = head.eom;
                  end
                  KIND_CODE: begin
                     seg_key   = 1'b1;
                     seg_units = head.code[head.first_bit] ? UNITS_DASH : UNITS_DOT;
                  end
                  default: begin
                     seg_units = UNITS_GAP;
                     seg_last  = 1'b1;
                  end
               endcase
            end
         end
         BK_ON: begin
            if (out_free) begin
               emit      = 1'b1;
               seg_key   = 1'b1;
               seg_units = code_ff[bit_ff] ? UNITS_DASH : UNITS_DOT;
            end
         end
         BK_OFF: begin
            if (out_free) begin
               emit = 1'b1;
               if (bit_ff == LAST_BIT) begin
                  seg_units = eom_ff ? UNITS_DOT : UNITS_GAP;
                  seg_last  = 1'b1;
                  seg_done  = eom_ff;
               end else begin
                  bit_in = BIT_W'(bit_ff + 3'd1);
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
      key_in       = emit ? seg_key : key_ff;
      dur_in       = emit ? seg_ticks(seg_units, element_ticks) : dur_ff;
      last_in      = emit ? seg_last : last_ff;
      done_in      = emit ? seg_done : done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff  <= bit_in;
      code_ff <= code_in;
      eom_ff  <= eom_in;
      key_ff  <= key_in;
      dur_ff  <= dur_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.key_on         = key_ff;
   assign rsp.duration_ticks = dur_ff;
   assign rsp.last_of_run    = last_ff;
   assign rsp.message_done   = done_ff;

endmodule

// ----- rtl/morse_character_keyer.sv -----
// Morse character keyer top level: front end, two-word queue, back end, unit register.
// An accepted character is written to the queue, then its first segment to the output register.
// Throughput: one segment word per cycle from the back-end sequencer unless the output stalls;
// a character gives 2*n segments for n elements (at most 5, so 10 segments), one for a space.
// Reset: queue and output empty, unit length register back to 100 ticks.
module morse_character_keyer import mck_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mck_req_if.sink   req_chan,
   mck_rsp_if.source rsp_chan,
   mck_csr_if.sink   csr_chan
);

   logic [TICKS_W-1:0] etick_ff, etick_in;
   logic               q_push;
   logic               q_pop;
   item_type           q_item;
   item_type           q_head;
   qstat_type          q_stat;

   assign csr_chan.ready = 1'b1;
   assign etick_in = csr_chan.valid ? csr_chan.element_ticks : etick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         etick_ff <= ELEMENT_TICKS_RESET;
      end else begin
         etick_ff <= etick_in;
      end
   end

   mck_front u_front (
      .req   (req_chan),
      .qstat (q_stat),
      .push  (q_push),
      .item  (q_item)
   );

   mck_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head      (q_head),
      .qstat     (q_stat)
   );

   mck_back u_back (
      .clock         (clock),
      .reset         (reset),
      .element_ticks (etick_ff),
      .head          (q_head),
      .qstat         (q_stat),
      .pop           (q_pop),
      .rsp           (rsp_chan)
   );

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.message_done |-> rsp_chan.last_of_run)
      else $error("message_done without last_of_run");

   a_on_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.key_on |-> !rsp_chan.last_of_run)
      else $error("key-down segment marked last");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("queue underflow");

endmodule
